@@ hw/rtl/arp_udp_receive_classifier_defines.svh @@
// ----------------------------------------------------------------------------
// arp/udp receive classifier assertion macros
// shared concurrent assertion forms, idle in reset, clocked on a given clock or on clk_i
// ----------------------------------------------------------------------------
`ifndef ARP_UDP_RECEIVE_CLASSIFIER_DEFINES_SVH
`define ARP_UDP_RECEIVE_CLASSIFIER_DEFINES_SVH

// generic clocked assertion with explicit clock and active-low reset
`define AUC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define AUC_ASSERT(label, prop, msg) \
  `AUC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/auc_pkg.sv @@
// ----------------------------------------------------------------------------
// auc_pkg
// types and constants of the arp/udp receive classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package auc_pkg;

  localparam int unsigned MAX_PAYLOAD = 576;
  localparam int unsigned MAX_FRAME   = 1600;

  localparam int unsigned POS_W   = 11;
  localparam int unsigned PLEN_W  = 10;
  localparam int unsigned IHL_W   = 6;

  // frame offsets
  localparam logic [POS_W-1:0] POS_TYPE_HI   = 11'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO   = 11'd13;
  localparam logic [POS_W-1:0] POS_L3_START  = 11'd14;
  localparam logic [POS_W-1:0] POS_ARP_OP_HI = 11'd20;
  localparam logic [POS_W-1:0] POS_ARP_OP    = 11'd21;
  localparam logic [POS_W-1:0] POS_ARP_SHA   = 11'd22;
  localparam logic [POS_W-1:0] POS_ARP_SHA_E = 11'd27;
  localparam logic [POS_W-1:0] POS_ARP_SPA   = 11'd28;
  localparam logic [POS_W-1:0] POS_ARP_SPA_E = 11'd31;
  localparam logic [POS_W-1:0] POS_ARP_TPA   = 11'd38;
  localparam logic [POS_W-1:0] POS_ARP_LAST  = 11'd41;
  localparam logic [POS_W-1:0] POS_IP_PROTO  = 11'd23;
  localparam logic [POS_W-1:0] POS_IP_SRC    = 11'd26;
  localparam logic [POS_W-1:0] POS_IP_SRC_E  = 11'd29;
  localparam logic [POS_W-1:0] POS_IP_DST    = 11'd30;
  localparam logic [POS_W-1:0] POS_IP_DST_E  = 11'd33;
  localparam logic [POS_W-1:0] POS_IP_MIN_END = 11'd34;

  // field values
  localparam logic [7:0]  ETYPE_HI      = 8'h08;
  localparam logic [7:0]  ETYPE_ARP_LO  = 8'h06;
  localparam logic [7:0]  ETYPE_IP_LO   = 8'h00;
  localparam logic [31:0] ARP_HW_PROTO  = 32'h0001_0800;
  localparam logic [7:0]  ARP_HLEN      = 8'd6;
  localparam logic [7:0]  ARP_PLEN      = 8'd4;
  localparam logic [7:0]  ARP_OP_REQ    = 8'd1;
  localparam logic [7:0]  ARP_OP_REPLY  = 8'd2;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  IP_MIN_IHL    = 4'd5;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

  typedef enum logic [0:0] {
    CFG_MY_IP     = 1'b0,
    CFG_SERVER_IP = 1'b1
  } auc_cfg_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_UDP       = 2'd1,
    KIND_ARP_REQ   = 2'd2,
    KIND_ARP_REPLY = 2'd3
  } auc_kind_e;

  typedef enum logic [3:0] {
    CLS_UNDEC  = 4'b0001,
    CLS_ARP    = 4'b0010,
    CLS_UDP    = 4'b0100,
    CLS_IGNORE = 4'b1000
  } auc_class_e;

  typedef struct packed {
    logic              valid;
    auc_kind_e         kind;
    logic [7:0]        payload_byte;
    logic [31:0]       source_address;
    logic [31:0]       dest_address;
    logic [15:0]       source_port;
    logic [15:0]       dest_port;
    logic [PLEN_W-1:0] payload_length;
    logic [47:0]       peer_mac;
    logic [31:0]       peer_address;
    logic              run_end;
  } auc_result_t;

endpackage

@@ hw/rtl/auc_parser.sv @@
// ----------------------------------------------------------------------------
// auc_parser
// per-word frame parser: holds frame state, forms at most one result a word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arp_udp_receive_classifier_defines.svh"

module auc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [31:0]         my_ip_i,
  input  logic [31:0]         server_ip_i,
  output auc_pkg::auc_result_t result_o
);
  import auc_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  auc_class_e        class_q, class_d, class_eff;
  logic [IHL_W-1:0]  ihl_q, ihl_d;
  logic [31:0]       src_ip_q, src_ip_d;
  logic [31:0]       dst_ip_q, dst_ip_d;
  logic [31:0]       ports_q, ports_d;
  logic [15:0]       udp_len_q, udp_len_d;
  logic [PLEN_W-1:0] count_q, count_d;
  logic [47:0]       mac_q, mac_d;
  logic [31:0]       sip_q, sip_d;
  logic [31:0]       tip_q, tip_d;
  logic [7:0]        op_q, op_d;

  logic [POS_W-1:0]  u0;
  logic [15:0]       len_diff;
  logic [PLEN_W-1:0] clip;
  logic              pay_here;
  logic              arp_req, arp_rep, summary, arp_bad;
  auc_result_t       res;

  // udp header start and clipped payload length
  always_comb begin
    u0       = POS_L3_START + POS_W'(ihl_q);
    len_diff = udp_len_q - UDP_HDR_BYTES;
    if (udp_len_q < UDP_HDR_BYTES) begin
      clip = '0;
    end else if (len_diff > 16'(MAX_PAYLOAD)) begin
      clip = PLEN_W'(MAX_PAYLOAD);
    end else begin
      clip = len_diff[PLEN_W-1:0];
    end
  end

  always_comb begin
    class_eff = (pos_q >= POS_W'(MAX_FRAME)) ? CLS_IGNORE : class_q;
    class_d   = class_eff;
    ihl_d     = ihl_q;
    src_ip_d  = src_ip_q;
    dst_ip_d  = dst_ip_q;
    ports_d   = ports_q;
    udp_len_d = udp_len_q;
    count_d   = count_q;
    mac_d     = mac_q;
    sip_d     = sip_q;
    tip_d     = tip_q;
    op_d      = op_q;
    pay_here  = 1'b0;
    arp_req   = 1'b0;
    arp_rep   = 1'b0;
    arp_bad   = (pos_q == POS_L3_START       && byte_i != ARP_HW_PROTO[31:24]) ||
                (pos_q == POS_L3_START + 11'd1 && byte_i != ARP_HW_PROTO[23:16]) ||
                (pos_q == POS_L3_START + 11'd2 && byte_i != ARP_HW_PROTO[15:8]) ||
                (pos_q == POS_L3_START + 11'd3 && byte_i != ARP_HW_PROTO[7:0]) ||
                (pos_q == POS_L3_START + 11'd4 && byte_i != ARP_HLEN) ||
                (pos_q == POS_L3_START + 11'd5 && byte_i != ARP_PLEN) ||
                (pos_q == POS_ARP_OP_HI && byte_i != 8'd0);

    case (class_eff)
      CLS_UNDEC: begin
        if (pos_q == POS_TYPE_HI && byte_i != ETYPE_HI) begin
          class_d = CLS_IGNORE;
        end else if (pos_q == POS_TYPE_LO) begin
          if (byte_i == ETYPE_ARP_LO) begin
            class_d = CLS_ARP;
          end else if (byte_i == ETYPE_IP_LO) begin
            class_d = CLS_UDP;
          end else begin
            class_d = CLS_IGNORE;
          end
        end
      end
      CLS_ARP: begin
        if (arp_bad) begin
          class_d = CLS_IGNORE;
        end else if (pos_q == POS_ARP_OP) begin
          op_d = byte_i;
        end else if (pos_q >= POS_ARP_SHA && pos_q <= POS_ARP_SHA_E) begin
          mac_d = {mac_q[39:0], byte_i};
        end else if (pos_q >= POS_ARP_SPA && pos_q <= POS_ARP_SPA_E) begin
          sip_d = {sip_q[23:0], byte_i};
        end else if (pos_q >= POS_ARP_TPA && pos_q <= POS_ARP_LAST) begin
          tip_d = {tip_q[23:0], byte_i};
          if (pos_q == POS_ARP_LAST) begin
            if (op_q == ARP_OP_REQ && my_ip_i != '0 && tip_d == my_ip_i) begin
              arp_req = 1'b1;
            end else if (op_q == ARP_OP_REPLY && server_ip_i != '0 &&
                         sip_q == server_ip_i) begin
              arp_rep = 1'b1;
            end
            class_d = CLS_IGNORE;
          end
        end
      end
      CLS_UDP: begin
        if (pos_q == POS_L3_START) begin
          if (byte_i[7:4] != IP_VERSION || byte_i[3:0] < IP_MIN_IHL) begin
            class_d = CLS_IGNORE;
          end else begin
            ihl_d = {byte_i[3:0], 2'b00};
          end
        end else if (pos_q == POS_IP_PROTO) begin
          if (byte_i != IP_PROTO_UDP) begin
            class_d = CLS_IGNORE;
          end
        end else if (pos_q >= POS_IP_SRC && pos_q <= POS_IP_SRC_E) begin
          src_ip_d = {src_ip_q[23:0], byte_i};
        end else if (pos_q >= POS_IP_DST && pos_q <= POS_IP_DST_E) begin
          dst_ip_d = {dst_ip_q[23:0], byte_i};
          if (pos_q == POS_IP_DST_E && dst_ip_d != '1 && dst_ip_d != my_ip_i) begin
            class_d = CLS_IGNORE;
          end
        end else if (pos_q >= u0 && pos_q <= u0 + 11'd3) begin
          ports_d = {ports_q[23:0], byte_i};
        end else if (pos_q == u0 + 11'd4 || pos_q == u0 + 11'd5) begin
          udp_len_d = {udp_len_q[7:0], byte_i};
          if (pos_q == u0 + 11'd5 && udp_len_d < UDP_HDR_BYTES) begin
            class_d = CLS_IGNORE;
          end
        end else if (pos_q >= u0 + 11'd8) begin
          if (count_q < clip) begin
            pay_here = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // closing summary on the last byte, once header and all clipped payload are in
    summary = last_i && class_d == CLS_UDP && pos_q >= POS_IP_MIN_END &&
              pos_q >= u0 + 11'd7 && count_d == clip;
  end

  // result word
  always_comb begin
    res = '0;
    if (arp_req || arp_rep) begin
      res.valid        = 1'b1;
      res.kind         = arp_req ? KIND_ARP_REQ : KIND_ARP_REPLY;
      res.peer_mac     = mac_q;
      res.peer_address = sip_q;
      res.run_end      = 1'b1;
    end else if (summary || (pay_here && !last_i)) begin
      res.valid          = 1'b1;
      res.kind           = summary ? KIND_UDP : KIND_PAYLOAD;
      res.payload_byte   = pay_here ? byte_i : 8'd0;
      res.source_address = src_ip_d;
      res.dest_address   = dst_ip_d;
      res.source_port    = ports_d[31:16];
      res.dest_port      = ports_d[15:0];
      res.payload_length = clip;
      res.run_end        = summary;
    end
    res.valid = res.valid && accept_i;
  end

  assign result_o = res;

  always_comb begin
    if (last_i) begin
      pos_d = '0;
    end else if (pos_q == '1) begin
      pos_d = pos_q;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      class_q   <= CLS_UNDEC;
      ihl_q     <= '0;
      count_q   <= '0;
      src_ip_q  <= '0;
      dst_ip_q  <= '0;
      ports_q   <= '0;
      udp_len_q <= '0;
      mac_q     <= '0;
      sip_q     <= '0;
      tip_q     <= '0;
      op_q      <= '0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      class_q   <= last_i ? CLS_UNDEC : class_d;
      ihl_q     <= last_i ? '0 : ihl_d;
      count_q   <= last_i ? '0 : count_d;
      src_ip_q  <= src_ip_d;
      dst_ip_q  <= dst_ip_d;
      ports_q   <= ports_d;
      udp_len_q <= udp_len_d;
      mac_q     <= mac_d;
      sip_q     <= sip_d;
      tip_q     <= tip_d;
      op_q      <= op_d;
    end
  end

  `AUC_ASSERT(a_last_restarts, accept_i && last_i |=> pos_q == '0 && count_q == '0, "frame end did not restart position")
  `AUC_ASSERT(a_arp_at_body_end, result_o.valid && (result_o.kind == KIND_ARP_REQ || result_o.kind == KIND_ARP_REPLY) |-> pos_q == POS_ARP_LAST, "arp result off the body end")
  `AUC_ASSERT(a_count_clipped, count_q <= PLEN_W'(MAX_PAYLOAD), "payload count beyond limit")
  `AUC_ASSERT(a_ihl_legal, ihl_q == '0 || ihl_q >= IHL_W'(20), "ip header length below minimum")

endmodule

@@ hw/rtl/arp_udp_receive_classifier.sv @@
// ----------------------------------------------------------------------------
// arp_udp_receive_classifier
// receive filter for ethernet frames carrying arp or ipv4/udp
// ----------------------------------------------------------------------------
// Frame bytes enter on the in channel (frame_byte_i, frame_last_i) with
// valid/ready, one word per byte, destination mac first. Results leave on the
// out channel: udp payload bytes (kind 0), a closing udp summary (kind 1),
// an arp request for our address (kind 2) or an arp reply from the server
// (kind 3). Frames that are malformed, not for us or cut short give no
// closing result.
// my_ip and server_ip are written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write them only while no frame is in flight; the block does not enforce this.
// Each byte is parsed in the cycle it is accepted; its result, if any, shows
// on the out channel in the next cycle from the output register. One byte is
// taken every cycle as long as that register is empty or being drained, so
// the sustained rate is one byte per clock.
// When the receiver stalls with a result held, in_ready_o drops until the
// result is taken. Reset clears the address registers and the frame state,
// so the next byte is treated as the first byte of a new frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_udp_receive_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [9:0]  payload_length_o,
  output logic [47:0] peer_mac_o,
  output logic [31:0] peer_address_o,
  output logic        run_end_o
);
  import auc_pkg::*;

  logic [31:0] my_ip_q, server_ip_q;
  logic        in_fire;
  logic        out_valid_q;
  auc_result_t res;
  auc_result_t out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_ip_q     <= '0;
      server_ip_q <= '0;
    end else if (cfg_we_i) begin
      case (auc_cfg_e'(cfg_index_i))
        CFG_MY_IP:     my_ip_q     <= cfg_data_i;
        CFG_SERVER_IP: server_ip_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  auc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .byte_i      (frame_byte_i),
    .last_i      (frame_last_i),
    .my_ip_i     (my_ip_q),
    .server_ip_i (server_ip_q),
    .result_o    (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign payload_byte_o   = out_q.payload_byte;
  assign source_address_o = out_q.source_address;
  assign dest_address_o   = out_q.dest_address;
  assign source_port_o    = out_q.source_port;
  assign dest_port_o      = out_q.dest_port;
  assign payload_length_o = out_q.payload_length;
  assign peer_mac_o       = out_q.peer_mac;
  assign peer_address_o   = out_q.peer_address;
  assign run_end_o        = out_q.run_end;

endmodule
